@@ sv/circle_rasterizer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// circle rasterizer assertion macros
// shared property forms for the rasterizer modules
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define CRAST_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("circle rasterizer assertion failed");

// next-cycle implication
`define CRAST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("circle rasterizer assertion failed");

`endif

@@ sv/crast_pkg.sv @@
// ----------------------------------------------------------------------------
// circle rasterizer package
// widths, codes and the job record passed from the stepper to the emitter
// ----------------------------------------------------------------------------
package crast_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int DEC_BITS    = RADIUS_BITS + 5;
    localparam int PIX_BITS    = COORD_BITS + 2;

    // job queue, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        OCT0 = 3'd0,
        OCT1 = 3'd1,
        OCT2 = 3'd2,
        OCT3 = 3'd3,
        OCT4 = 3'd4,
        OCT5 = 3'd5,
        OCT6 = 3'd6,
        OCT7 = 3'd7
    } octant_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  origin_x;
        logic [COORD_BITS-1:0]  origin_y;
        logic [RADIUS_BITS-1:0] arc_x;
        logic [RADIUS_BITS-1:0] arc_y;
        logic                   done;
    } crast_job_t;

endpackage

@@ sv/circle_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// circle rasterizer unit
// midpoint circle rasterizer: start and step requests in, octant pixels out
// ----------------------------------------------------------------------------
// A start request latches radius and centre and emits the eight symmetric
// pixels of (0, radius); each step request advances the arc one point and
// emits its eight pixels, the final step flagging circle_done on all eight.
// A step with no circle in progress gives no pixels. Pixels leave one per
// cycle while m_ready is held, from the registered output of the
// single-pixel emitter; the stepper registers each arc update, and a
// two-entry job queue lets it take requests ahead of the emitter, so it can
// accept further requests while the emitter is still busy.
module circle_rasterizer_unit
    import crast_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [RADIUS_BITS-1:0]     s_radius,
    input  logic [COORD_BITS-1:0]      s_center_x,
    input  logic [COORD_BITS-1:0]      s_center_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [PIX_BITS-1:0] m_pixel_x,
    output logic signed [PIX_BITS-1:0] m_pixel_y,
    output logic [2:0]                 m_octant,
    output logic                       m_last_of_step,
    output logic                       m_circle_done
);

    logic       push_valid;
    logic       push_ready;
    crast_job_t push_job;
    logic       pop_valid;
    logic       pop_ready;
    crast_job_t pop_job;

    crast_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_radius   (s_radius),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .job_valid  (push_valid),
        .job_ready  (push_ready),
        .job        (push_job)
    );

    crast_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    crast_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (pop_valid),
        .job_ready      (pop_ready),
        .job            (pop_job),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_octant       (m_octant),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

endmodule

@@ sv/crast_front.sv @@
// ----------------------------------------------------------------------------
// circle rasterizer stepper
// accepts requests, keeps the arc state and pushes one job per emitting request
// ----------------------------------------------------------------------------
`include "circle_rasterizer_unit_assert.svh"

module crast_front
    import crast_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [RADIUS_BITS-1:0] s_radius,
    input  logic [COORD_BITS-1:0]  s_center_x,
    input  logic [COORD_BITS-1:0]  s_center_y,
    output logic                   job_valid,
    input  logic                   job_ready,
    output crast_job_t             job
);

    logic [RADIUS_BITS-1:0] arc_x_reg, arc_x_next;
    logic [RADIUS_BITS-1:0] arc_y_reg, arc_y_next;
    logic [DEC_BITS-1:0]    dec_reg, dec_next;
    logic [COORD_BITS-1:0]  origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0]  origin_y_reg, origin_y_next;
    logic                   active_reg, active_next;

    logic                   accept;
    logic                   is_start;
    logic                   dec_neg;
    logic [DEC_BITS-1:0]    x_ext;
    logic [DEC_BITS-1:0]    diff;
    logic [DEC_BITS-1:0]    dec_inc;
    logic [DEC_BITS-1:0]    radius_x2;
    logic [RADIUS_BITS-1:0] step_x;
    logic [RADIUS_BITS-1:0] step_y;
    logic                   step_done;

    assign s_ready  = job_ready;
    assign accept   = s_valid && s_ready;
    assign is_start = (opcode_t'(s_opcode) == OP_START);

    // Bresenham decision update on the old point
    assign dec_neg   = dec_reg[DEC_BITS-1];
    assign x_ext     = DEC_BITS'(arc_x_reg);
    assign diff      = DEC_BITS'(arc_x_reg) - DEC_BITS'(arc_y_reg);
    assign dec_inc   = dec_neg ? ({x_ext[DEC_BITS-3:0], 2'b00} + DEC_BITS'(6))
                               : ({diff[DEC_BITS-3:0], 2'b00} + DEC_BITS'(10));
    assign step_x    = arc_x_reg + RADIUS_BITS'(1);
    assign step_y    = (!dec_neg && (arc_y_reg != '0)) ? arc_y_reg - RADIUS_BITS'(1)
                                                       : arc_y_reg;
    assign step_done = (step_x > step_y);
    assign radius_x2 = {(DEC_BITS-RADIUS_BITS-1)'(0), s_radius, 1'b0};

    assign job_valid = s_valid && (is_start || active_reg);

    always_comb begin
        arc_x_next    = arc_x_reg;
        arc_y_next    = arc_y_reg;
        dec_next      = dec_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        active_next   = active_reg;
        job.origin_x  = origin_x_reg;
        job.origin_y  = origin_y_reg;
        job.arc_x     = step_x;
        job.arc_y     = step_y;
        job.done      = step_done;
        if (is_start) begin
            job.origin_x = s_center_x;
            job.origin_y = s_center_y;
            job.arc_x    = '0;
            job.arc_y    = s_radius;
            job.done     = 1'b0;
        end
        if (accept) begin
            if (is_start) begin
                arc_x_next    = '0;
                arc_y_next    = s_radius;
                dec_next      = DEC_BITS'(3) - radius_x2;
                origin_x_next = s_center_x;
                origin_y_next = s_center_y;
                active_next   = 1'b1;
            end else if (active_reg) begin
                arc_x_next  = step_x;
                arc_y_next  = step_y;
                dec_next    = dec_reg + dec_inc;
                active_next = !step_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arc_x_reg    <= '0;
            arc_y_reg    <= '0;
            dec_reg      <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            active_reg   <= 1'b0;
        end else begin
            arc_x_reg    <= arc_x_next;
            arc_y_reg    <= arc_y_next;
            dec_reg      <= dec_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            active_reg   <= active_next;
        end
    end

    `CRAST_ASSERT_NEXT(a_start_arms, aclk, aresetn, accept && is_start, active_reg)
    `CRAST_ASSERT_NOW(a_done_job_pushed, aclk, aresetn, accept && active_reg && !is_start && step_done, job_valid && job.done)
    `CRAST_ASSERT_NEXT(a_idle_step_holds, aclk, aresetn, accept && !is_start && !active_reg, !active_reg && $stable(arc_x_reg) && $stable(dec_reg))

endmodule

@@ sv/crast_queue.sv @@
// ----------------------------------------------------------------------------
// circle rasterizer job queue
// short register queue between stepper and emitter
// ----------------------------------------------------------------------------
`include "circle_rasterizer_unit_assert.svh"

module crast_queue
    import crast_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  crast_job_t push_job,
    output logic       pop_valid,
    input  logic       pop_ready,
    output crast_job_t pop_job
);

    crast_job_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = (cnt_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_BITS'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_BITS'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `CRAST_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= QCNT_BITS'(QUEUE_DEPTH))
    `CRAST_ASSERT_NOW(a_ptr_gap, aclk, aresetn, cnt_reg != QCNT_BITS'(QUEUE_DEPTH), QPTR_BITS'(wr_ptr_reg - rd_ptr_reg) == QPTR_BITS'(cnt_reg))
    `CRAST_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, cnt_reg == '0, !pop)

endmodule

@@ sv/crast_back.sv @@
// ----------------------------------------------------------------------------
// circle rasterizer pixel emitter
// walks the head job's eight octants, one registered pixel per unstalled cycle
// ----------------------------------------------------------------------------
`include "circle_rasterizer_unit_assert.svh"

module crast_back
    import crast_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  crast_job_t                 job,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [PIX_BITS-1:0] m_pixel_x,
    output logic signed [PIX_BITS-1:0] m_pixel_y,
    output logic [2:0]                 m_octant,
    output logic                       m_last_of_step,
    output logic                       m_circle_done
);

    octant_t               oct_reg;
    logic                  m_valid_reg;
    logic [PIX_BITS-1:0]   pix_x_reg, pix_x_next;
    logic [PIX_BITS-1:0]   pix_y_reg, pix_y_next;
    logic [2:0]            octant_reg;
    logic                  last_reg;
    logic                  done_reg;

    logic                  load;
    logic                  swap;
    logic                  neg_x;
    logic                  neg_y;
    logic [PIX_BITS-1:0]   off_x;
    logic [PIX_BITS-1:0]   off_y;

    assign load      = job_valid && (!m_valid_reg || m_ready);
    assign job_ready = load && (oct_reg == OCT7);

    always_comb begin
        swap  = 1'b0;
        neg_x = 1'b0;
        neg_y = 1'b0;
        case (oct_reg)
            OCT0:    begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b0; end
            OCT1:    begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b0; end
            OCT2:    begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b1; end
            OCT3:    begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b1; end
            OCT4:    begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b1; end
            OCT5:    begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b1; end
            OCT6:    begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b0; end
            OCT7:    begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b0; end
            default: begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b0; end
        endcase
        off_x      = swap ? PIX_BITS'(job.arc_y) : PIX_BITS'(job.arc_x);
        off_y      = swap ? PIX_BITS'(job.arc_x) : PIX_BITS'(job.arc_y);
        pix_x_next = neg_x ? PIX_BITS'(job.origin_x) - off_x
                           : PIX_BITS'(job.origin_x) + off_x;
        pix_y_next = neg_y ? PIX_BITS'(job.origin_y) - off_y
                           : PIX_BITS'(job.origin_y) + off_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_reg     <= OCT0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                oct_reg     <= octant_t'(oct_reg + 3'd1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_x_reg  <= pix_x_next;
            pix_y_reg  <= pix_y_next;
            octant_reg <= oct_reg;
            last_reg   <= (oct_reg == OCT7);
            done_reg   <= job.done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = $signed(pix_x_reg);
    assign m_pixel_y      = $signed(pix_y_reg);
    assign m_octant       = octant_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

    `CRAST_ASSERT_NOW(a_last_on_oct7, aclk, aresetn, m_valid_reg, m_last_of_step == (octant_t'(octant_reg) == OCT7))
    `CRAST_ASSERT_NEXT(a_job_held_mid_run, aclk, aresetn, oct_reg != OCT0 && oct_reg != OCT7, job_valid)
    `CRAST_ASSERT_NEXT(a_octant_follows, aclk, aresetn, load, octant_t'(octant_reg) == octant_t'($past(oct_reg)))

endmodule
